### hw/rtl/bfc_pkg.sv
// bfc_pkg: shared types, constants and the checksum add for the block framer
// used by bfc_front, bfc_queue, bfc_back and block_framer_with_checksum
package bfc_pkg;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PAD     = 2'd1;
    localparam logic [1:0] KIND_CHECK   = 2'd2;

    localparam logic [7:0] PAD_EVEN = 8'hED;
    localparam logic [7:0] PAD_ODD  = 8'h11;

    localparam int QUEUE_DEPTH = 2;

    // one request from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       close;
        logic       pad;
    } cmd_t;

    typedef enum logic [1:0] {
        S_DATA,
        S_PAD,
        S_CKHI,
        S_CKLO
    } state_t;

    // 16-bit add with end-around carry
    function automatic logic [15:0] ocs_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

### hw/rtl/bfc_front.sv
// bfc_front: accepts source bytes and classifies each one against the frame position
// depends on bfc_pkg
module bfc_front #(
    parameter int PAYLOAD_BYTES = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_eof,
    output logic          push,
    output bfc_pkg::cmd_t push_cmd,
    input  logic          q_full
);

    localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(PAYLOAD_BYTES - 1);

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic          last;

    assign in_ready = !q_full;
    assign push     = in_valid && in_ready;
    assign last     = (pos_reg == LAST_POS);

    assign push_cmd.data  = in_byte;
    assign push_cmd.close = last;
    assign push_cmd.pad   = in_eof && !last;

    always_comb
    begin
        pos_next = pos_reg;
        if (push)
        begin
            if (last || in_eof)
                pos_next = '0;
            else
                pos_next = pos_reg + PW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

### hw/rtl/bfc_queue.sv
// bfc_queue: small register queue of requests between front and back
// depends on bfc_pkg
module bfc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bfc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output bfc_pkg::cmd_t head_cmd,
    output logic          full,
    output logic          not_empty
);

    localparam int DEPTH = bfc_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    bfc_pkg::cmd_t entry_reg [DEPTH];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] wr_next;
    logic [AW-1:0] rd_reg;
    logic [AW-1:0] rd_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_reg];

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1);
        if (pop)
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_cmd;
    end

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

### hw/rtl/bfc_back.sv
// bfc_back: output sequencer emitting payload, pad and checksum bytes
// depends on bfc_pkg; takes requests from bfc_queue
module bfc_back #(
    parameter int PAYLOAD_BYTES = 18
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  bfc_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic [1:0]    out_kind,
    output logic          out_eof,
    output logic          out_eor
);

    localparam int PW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(PAYLOAD_BYTES - 1);
    localparam logic ODD_LEN = logic'(PAYLOAD_BYTES % 2);

    bfc_pkg::state_t state_reg;
    bfc_pkg::state_t state_next;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [15:0]   sum_reg;
    logic [15:0]   sum_next;
    logic [7:0]    held_reg;
    logic [7:0]    held_next;
    logic          pad_odd_reg;
    logic          pad_odd_next;
    logic [7:0]    ck_lo_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic [1:0]    out_kind_reg;
    logic          out_eof_reg;
    logic          out_eor_reg;

    logic          adv;
    logic          load;
    logic [7:0]    load_byte;
    logic [1:0]    load_kind;
    logic          load_eof;
    logic          load_eor;
    logic          take;
    logic [7:0]    take_byte;
    logic [15:0]   sum_fin;
    logic [15:0]   check;
    logic [7:0]    pad_byte;

    assign adv      = !out_valid_reg || out_ready;
    assign pad_byte = pad_odd_reg ? bfc_pkg::PAD_ODD : bfc_pkg::PAD_EVEN;
    assign sum_fin  = ODD_LEN ? bfc_pkg::ocs_add(sum_reg, {held_reg, 8'h00}) : sum_reg;
    assign check    = ~sum_fin;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfc_pkg::S_DATA:
            begin
                if (q_valid && adv)
                begin
                    if (q_cmd.close)
                        state_next = bfc_pkg::S_CKHI;
                    else if (q_cmd.pad)
                        state_next = bfc_pkg::S_PAD;
                end
            end
            bfc_pkg::S_PAD:
            begin
                if (adv && pos_reg == LAST_POS)
                    state_next = bfc_pkg::S_CKHI;
            end
            bfc_pkg::S_CKHI:
            begin
                if (adv)
                    state_next = bfc_pkg::S_CKLO;
            end
            bfc_pkg::S_CKLO:
            begin
                if (adv)
                    state_next = bfc_pkg::S_DATA;
            end
            default:
                state_next = bfc_pkg::S_DATA;
        endcase
    end

    // outputs
    always_comb
    begin
        load      = 1'b0;
        load_byte = '0;
        load_kind = bfc_pkg::KIND_PAYLOAD;
        load_eof  = 1'b0;
        load_eor  = 1'b0;
        pop       = 1'b0;
        take      = 1'b0;
        take_byte = '0;
        case (state_reg)
            bfc_pkg::S_DATA:
            begin
                if (q_valid && adv)
                begin
                    load      = 1'b1;
                    pop       = 1'b1;
                    take      = 1'b1;
                    take_byte = q_cmd.data;
                    load_byte = q_cmd.data;
                    load_eor  = !(q_cmd.close || q_cmd.pad);
                end
            end
            bfc_pkg::S_PAD:
            begin
                if (adv)
                begin
                    load      = 1'b1;
                    take      = 1'b1;
                    take_byte = pad_byte;
                    load_byte = pad_byte;
                    load_kind = bfc_pkg::KIND_PAD;
                end
            end
            bfc_pkg::S_CKHI:
            begin
                if (adv)
                begin
                    load      = 1'b1;
                    load_byte = check[15:8];
                    load_kind = bfc_pkg::KIND_CHECK;
                end
            end
            bfc_pkg::S_CKLO:
            begin
                if (adv)
                begin
                    load      = 1'b1;
                    load_byte = ck_lo_reg;
                    load_kind = bfc_pkg::KIND_CHECK;
                    load_eof  = 1'b1;
                    load_eor  = 1'b1;
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    // frame position, running sum and pad parity
    always_comb
    begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        held_next    = held_reg;
        pad_odd_next = pad_odd_reg;
        if (take)
        begin
            if (!pos_reg[0])
                held_next = take_byte;
            else
                sum_next = bfc_pkg::ocs_add(sum_reg, {held_reg, take_byte});
            if (pos_reg != LAST_POS)
                pos_next = pos_reg + PW'(1);
        end
        if (state_reg == bfc_pkg::S_DATA && pop)
            pad_odd_next = 1'b0;
        else if (state_reg == bfc_pkg::S_PAD && take)
            pad_odd_next = !pad_odd_reg;
        if (state_reg == bfc_pkg::S_CKLO && adv)
        begin
            pos_next  = '0;
            sum_next  = '0;
            held_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bfc_pkg::S_DATA;
            pos_reg       <= '0;
            sum_reg       <= '0;
            held_reg      <= '0;
            pad_odd_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            held_reg      <= held_next;
            pad_odd_reg   <= pad_odd_next;
            out_valid_reg <= load || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= load_byte;
            out_kind_reg <= load_kind;
            out_eof_reg  <= load_eof;
            out_eor_reg  <= load_eor;
        end
        if (state_reg == bfc_pkg::S_CKHI && adv)
            ck_lo_reg <= check[7:0];
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_kind  = out_kind_reg;
    assign out_eof   = out_eof_reg;
    assign out_eor   = out_eor_reg;

`ifndef SYNTH
    a_pad_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfc_pkg::S_PAD) |-> (pos_reg != '0))
        else $error("pad state entered at frame start");
    a_pop_in_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == bfc_pkg::S_DATA))
        else $error("request taken outside data state");
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfc_pkg::S_CKLO && adv) |=> (sum_reg == '0 && pos_reg == '0))
        else $error("frame state not cleared after checksum");
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eof_reg) |-> (out_eor_reg && out_kind_reg == bfc_pkg::KIND_CHECK))
        else $error("frame end not on closing checksum byte");
`endif

endmodule

### hw/rtl/block_framer_with_checksum.sv
// block_framer_with_checksum: top level of the byte framer with 16-bit checksum
// depends on bfc_pkg, bfc_front, bfc_queue and bfc_back
//
// Source bytes are passed through and grouped into frames of PAYLOAD_BYTES bytes; each
// frame is followed by the complemented 16-bit one's-complement sum of its big-endian
// byte pairs, high byte first. A file that ends inside a frame is padded with 0xED, 0x11
// alternating before the checksum. Every output byte passes through the single output
// sequencer: a closed frame adds two checksum bytes and an early end of file adds up to
// PAYLOAD_BYTES - 1 pad bytes more. A two-request queue sits in front of the sequencer,
// so input keeps flowing at one byte per cycle until it fills during a pad or checksum
// burst or while the output stalls.
module block_framer_with_checksum #(
    parameter int PAYLOAD_BYTES = 18
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tlast,   // end_of_file
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // frame_byte
    output logic [2:0] m_tuser,   // byte_kind [1:0], end_of_frame [2]
    output logic       m_tlast    // end_of_run
);

    logic          push;
    bfc_pkg::cmd_t push_cmd;
    logic          pop;
    bfc_pkg::cmd_t head_cmd;
    logic          q_full;
    logic          q_valid;
    logic [1:0]    kind;
    logic          eof_frame;

    bfc_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eof   (s_tlast),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    bfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .head_cmd  (head_cmd),
        .full      (q_full),
        .not_empty (q_valid)
    );

    bfc_back #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (head_cmd),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_kind  (kind),
        .out_eof   (eof_frame),
        .out_eor   (m_tlast)
    );

    assign m_tuser = {eof_frame, kind};

endmodule

### bench/block_framer_with_checksum_test.sv
// block_framer_with_checksum_test: self-checking bench for the byte framer with 16-bit checksum
// depends on bfc_pkg and block_framer_with_checksum; a scoreboard class predicts every output
// byte from the accepted requests, and random stalls on both stream sides exercise the queue

module block_framer_with_checksum_test;

    localparam int FRAME_LEN   = 18;
    localparam int ITEM_TARGET = 470;
    localparam int QUIET_LIMIT = 2000;

    class frame_scoreboard;
        typedef struct packed {
            logic [7:0] frame_byte;
            logic [1:0] byte_kind;
            logic       end_of_frame;
            logic       end_of_run;
        } out_byte_t;

        out_byte_t   expected_q[$];
        int          pos_in_frame = 0;
        logic [15:0] frame_sum = 16'h0000;
        logic [7:0]  high_byte = 8'h00;
        int          errors = 0;

        function void add_word(logic [15:0] word);
            logic [16:0] s;
            s = {1'b0, frame_sum} + {1'b0, word};
            frame_sum = s[15:0] + {15'd0, s[16]};
        endfunction

        function void take_byte(logic [7:0] b);
            if (pos_in_frame % 2 == 0)
                high_byte = b;
            else
                add_word({high_byte, b});
            pos_in_frame++;
        endfunction

        function void push(logic [7:0] b, logic [1:0] kind, logic eof_frame);
            out_byte_t e;
            e.frame_byte   = b;
            e.byte_kind    = kind;
            e.end_of_frame = eof_frame;
            e.end_of_run   = 1'b0;
            expected_q.push_back(e);
        endfunction

        function void close_frame();
            logic [15:0] check;
            if (pos_in_frame % 2 != 0)
                add_word({high_byte, 8'h00});
            check = ~frame_sum;
            push(check[15:8], bfc_pkg::KIND_CHECK, 1'b0);
            push(check[7:0], bfc_pkg::KIND_CHECK, 1'b1);
            pos_in_frame = 0;
            frame_sum    = 16'h0000;
            high_byte    = 8'h00;
        endfunction

        // accepted request: queue every byte it will cause
        function void note_byte(logic [7:0] b, logic eof);
            out_byte_t last_e;
            int        pad_index;
            push(b, bfc_pkg::KIND_PAYLOAD, 1'b0);
            take_byte(b);
            if (pos_in_frame >= FRAME_LEN)
                close_frame();
            else if (eof && pos_in_frame != 0)
            begin
                pad_index = 0;
                while (pos_in_frame < FRAME_LEN)
                begin
                    push(pad_index % 2 ? bfc_pkg::PAD_ODD : bfc_pkg::PAD_EVEN,
                         bfc_pkg::KIND_PAD, 1'b0);
                    take_byte(pad_index % 2 ? bfc_pkg::PAD_ODD : bfc_pkg::PAD_EVEN);
                    pad_index++;
                end
                close_frame();
            end
            last_e = expected_q.pop_back();
            last_e.end_of_run = 1'b1;
            expected_q.push_back(last_e);
        endfunction

        function void compare(string field, int exp_v, int got_v);
            if (exp_v != got_v)
            begin
                $error("%s: expected %0h, got %0h", field, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_byte(logic [7:0] data, logic [2:0] user, logic last);
            out_byte_t e;
            if (expected_q.size() == 0)
            begin
                $error("frame_byte: expected nothing, got %0h", data);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare("frame_byte", e.frame_byte, data);
            compare("byte_kind", e.byte_kind, user[1:0]);
            compare("end_of_frame", e.end_of_frame, user[2]);
            compare("end_of_run", e.end_of_run, last);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    frame_scoreboard sb = new;
    int              items_sent = 0;
    int              quiet_cycles = 0;
    logic            calm = 1'b0;

    block_framer_with_checksum #(
        .PAYLOAD_BYTES(FRAME_LEN)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // output side stalls at random
    always @(negedge clk)
        if (rst_n)
            m_tready <= calm || ($urandom_range(99) >= 24);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tuser, m_tlast);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eof);
        calm = (items_sent >= 180 && items_sent < 300);
        while (!calm && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_byte(b, eof);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_file(input int len, input int fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (fill)
                1:       b = 8'hFF;
                2:       b = 8'h00;
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    initial
    begin
        int len;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // one-byte file, longest pad burst
        send_byte(8'hFF, 1'b1);
        // end of file on the frame boundary, all ones for heavy carry folding
        send_file(FRAME_LEN, 1);
        // short files ending on even and odd positions
        send_file(2, 2);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hAA, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(9))
                0:       len = $urandom_range(2 * FRAME_LEN + 1, 3 * FRAME_LEN + 5);
                1:       len = FRAME_LEN;
                2:       len = $urandom_range(1, 3);
                default: len = $urandom_range(1, 2 * FRAME_LEN);
            endcase
            send_file(len, $urandom_range(9) == 0 ? $urandom_range(1, 2) : 0);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (FRAME_LEN + 8) @(posedge clk);

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
hw/rtl/bfc_pkg.sv
hw/rtl/bfc_front.sv
hw/rtl/bfc_queue.sv
hw/rtl/bfc_back.sv
hw/rtl/block_framer_with_checksum.sv
bench/block_framer_with_checksum_test.sv
